// ----- rtl/agkf_pkg.sv -----
// Types, constants and saturating helpers for the angle / gyro-bias Kalman filter.
package agkf_pkg;

   typedef struct packed {
      logic signed [31:0] accel_angle;
      logic signed [31:0] gyro_rate;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] corrected_rate;
   } rsp_payload_type;

   localparam logic [1:0] CSR_Q_ANGLE = 2'd0;
   localparam logic [1:0] CSR_Q_BIAS  = 2'd1;
   localparam logic [1:0] CSR_R       = 2'd2;
   localparam logic [1:0] CSR_DT      = 2'd3;
   localparam int CSR_IDX_W = 8;
   localparam int MUL_DIG   = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LOAD,
      ST_MUL_RUN,
      ST_MUL_DONE,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_DONE,
      ST_STEP,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [65:0] s;
      s = 66'(a) + 66'(b);
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [65:0] s;
      s = 66'(a) - 66'(b);
      return sat32(s);
   endfunction

endpackage

// ----- rtl/agkf_mul.sv -----
// Digit-serial signed 32x32 multiplier with round-half-up shift and saturation.
module agkf_mul import agkf_pkg::*; #(
   parameter int FRAC_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic               busy,
   output logic signed [31:0] result
);
   localparam int STEPS = 32 / MUL_DIG;
   localparam int CW = $clog2(STEPS + 1);

   logic signed [65:0] acc_ff, acc_in;
   logic [31:0] mplr_ff, mplr_in;
   logic signed [31:0] mcand_ff, mcand_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [65:0] pp, rnd, fin;

   always_comb begin
      acc_in   = acc_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      pp = 66'(mcand_ff) * $signed({1'b0, mplr_ff[MUL_DIG-1:0]});
      if (start) begin
         acc_in   = '0;
         mplr_in  = op_b;
         mcand_in = op_a;
         cnt_in   = CW'(STEPS);
      end else if (cnt_ff != '0) begin
         // top digit of a signed multiplier has negative weight
         if (cnt_ff == CW'(1))
            pp = 66'(mcand_ff) * $signed(mplr_ff[MUL_DIG-1:0]);
         acc_in  = (acc_ff >>> MUL_DIG) + (pp <<< (32 - MUL_DIG));
         mplr_in = mplr_ff >> MUL_DIG;
         cnt_in  = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      acc_ff   <= acc_in;
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
   end

   assign rnd = acc_ff + (66'sd1 <<< (FRAC_BITS - 1));
   assign fin = rnd >>> FRAC_BITS;
   assign result = sat32(fin);
   assign busy = (cnt_ff != '0);
endmodule

// ----- rtl/agkf_div.sv -----
// Bit-serial restoring divider for the Kalman gain, truncating toward zero.
module agkf_div import agkf_pkg::*; #(
   parameter int FRAC_BITS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               busy,
   output logic signed [31:0] result
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dv_ff, dv_in;
   logic neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [32:0] trial;
   logic [NW:0] q_s;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dv_in  = dv_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff[31:0], quo_ff[NW-1]};
      if (start) begin
         neg_in = num[31];
         quo_in = {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
         rem_in = '0;
         dv_in  = den;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dv_ff}) begin
            rem_in = trial - {1'b0, dv_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      q_s = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};
      result = sat32(66'($signed(q_s)));
   end
   assign busy = (cnt_ff != '0);
endmodule

// ----- rtl/angle_gyro_kalman_filter_top.sv -----
// Top level of the two-state angle / gyro-bias Kalman filter.
// One request at a time: after acceptance the response is computed from eleven products
// through a 4-bit-per-cycle serial multiplier and two 52-step bit-serial divisions
// for the gains, then passes the ST_STEP and ST_OUT states; when the innovation
// variance is not positive the divisions are skipped. The response is held in an
// output register; the next request may be accepted while it waits, and its own
// response waits until it is taken. Configuration writes complete at once.
module angle_gyro_kalman_filter_top import agkf_pkg::*; #(
   parameter int FRAC_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   logic [20:0] qa_ff, qb_ff, dt_ff;
   logic [24:0] r_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] meas_ff, meas_in, rate_ff, rate_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, err_ff, err_in;
   logic signed [31:0] pc0_ff, pc0_in, t1_ff, t1_in, e_ff, e_in;
   logic [3:0] step_ff, step_in;
   state_type state_ff, state_in;
   rsp_payload_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic mul_start, mul_busy, div_start, div_busy;
   logic signed [31:0] ma, mb, mres, dn, dres;

   agkf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(ma), .op_b(mb), .busy(mul_busy), .result(mres));

   agkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(dn), .den(e_ff), .busy(div_busy), .result(dres));

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= 21'd1049;
         qb_ff <= 21'd3146;
         r_ff  <= 25'd524288;
         dt_ff <= 21'd5243;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IDX_W'(CSR_Q_ANGLE): qa_ff <= csr_data[20:0];
            CSR_IDX_W'(CSR_Q_BIAS):  qb_ff <= csr_data[20:0];
            CSR_IDX_W'(CSR_R):       r_ff  <= csr_data[24:0];
            CSR_IDX_W'(CSR_DT):      dt_ff <= csr_data[20:0];
            default: ;
         endcase
      end
   end

   // multiplier operands for each product step
   always_comb begin
      ma = '0;
      mb = $signed({11'd0, dt_ff});
      case (step_ff)
         4'd0: ma = qsub(rate_ff, bias_ff);
         4'd1: ma = qsub(qsub($signed({11'd0, qa_ff}), p01_ff), p10_ff);
         4'd2: ma = qsub(32'sd0, p11_ff);
         4'd3: ma = qsub(32'sd0, p11_ff);
         4'd4: ma = $signed({11'd0, qb_ff});
         4'd5: begin ma = k0_ff; mb = pc0_ff; end
         4'd6: begin ma = k0_ff; mb = t1_ff; end
         4'd7: begin ma = k1_ff; mb = pc0_ff; end
         4'd8: begin ma = k1_ff; mb = t1_ff; end
         4'd9: begin ma = k0_ff; mb = err_ff; end
         4'd10: begin ma = k1_ff; mb = err_ff; end
         default: ;
      endcase
   end
   assign dn = (state_ff == ST_DIV_DONE) ? p10_ff : pc0_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      ang_in = ang_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      meas_in = meas_ff; rate_in = rate_ff;
      k0_in = k0_ff; k1_in = k1_ff; err_in = err_ff;
      pc0_in = pc0_ff; t1_in = t1_ff; e_in = e_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               meas_in = req_payload.accel_angle;
               rate_in = req_payload.gyro_rate;
               step_in = '0;
               state_in = ST_MUL_LOAD;
            end
         end
         ST_MUL_LOAD: begin
            mul_start = 1'b1;
            state_in = ST_MUL_RUN;
         end
         ST_MUL_RUN: if (!mul_busy) state_in = ST_MUL_DONE;
         ST_MUL_DONE: begin
            state_in = ST_MUL_LOAD;
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: ang_in = qadd(ang_ff, mres);
               4'd1: p00_in = qadd(p00_ff, mres);
               4'd2: p01_in = qadd(p01_ff, mres);
               4'd3: p10_in = qadd(p10_ff, mres);
               4'd4: begin
                  p11_in = qadd(p11_ff, mres);
                  err_in = qsub(meas_ff, ang_ff);
                  pc0_in = p00_ff;
                  t1_in = p01_ff;
                  e_in = qadd($signed({7'd0, r_ff}), p00_ff);
                  step_in = '0;
                  state_in = ST_DIV_LOAD;
               end
               4'd5: p00_in = qsub(p00_ff, mres);
               4'd6: p01_in = qsub(p01_ff, mres);
               4'd7: p10_in = qsub(p10_ff, mres);
               4'd8: p11_in = qsub(p11_ff, mres);
               4'd9: ang_in = qadd(ang_ff, mres);
               default: begin
                  bias_in = qadd(bias_ff, mres);
                  state_in = ST_STEP;
               end
            endcase
         end
         ST_DIV_LOAD: begin
            if (e_ff[31] || e_ff == '0) begin
               k0_in = '0;
               k1_in = '0;
               step_in = 4'd5;
               state_in = ST_MUL_LOAD;
            end else begin
               div_start = 1'b1;
               state_in = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: if (!div_busy) state_in = ST_DIV_DONE;
         ST_DIV_DONE: begin
            if (step_ff == 4'd0) begin
               k0_in = dres;
               step_in = 4'd1;
               div_start = 1'b1;
               state_in = ST_DIV_RUN;
            end else begin
               k1_in = dres;
               step_in = 4'd5;
               state_in = ST_MUL_LOAD;
            end
         end
         ST_STEP: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               out_in.filtered_angle = ang_ff;
               out_in.corrected_rate = qsub(rate_ff, bias_ff);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
         ang_ff <= '0;
         bias_ff <= '0;
         p00_ff <= ONE;
         p01_ff <= '0;
         p10_ff <= '0;
         p11_ff <= ONE;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff <= step_in;
         ang_ff <= ang_in;
         bias_ff <= bias_in;
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
      end
      meas_ff <= meas_in;
      rate_ff <= rate_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      err_ff <= err_in;
      pc0_ff <= pc0_in;
      t1_ff <= t1_in;
      e_ff <= e_in;
      out_ff <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = out_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("request accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response dropped");
   a_units_excl: assert property (@(posedge clock) disable iff (reset)
      !(mul_busy && div_busy)) else $error("units overlap");
endmodule

// ----- tb/tb_top.sv -----
// Testbench for the angle / gyro-bias Kalman filter: directed table, then random samples.
`timescale 1ns / 1ps
module tb_top;
   import agkf_pkg::*;

   localparam int FB = 20;
   localparam int LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   angle_gyro_kalman_filter_top #(.FRAC_BITS(FB)) dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // filter state mirrored in the predictor
   logic signed [31:0] est_angle, est_bias;
   logic signed [31:0] cov [4];
   logic [31:0] q_angle, q_bias, r_noise, dt_step;
   rsp_payload_type expected_rsp [$];
   int errors = 0;
   int cycles = 0;
   int rsp_gap = 0;
   bit rsp_idle_on = 1'b1;
   bit hold_rsp = 1'b0;
   bit stim_done = 1'b0;

   function automatic logic signed [31:0] sat(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [127:0] p;
      p = 128'(a) * 128'(b) + (128'sd1 <<< (FB - 1));
      return sat(p >>> FB);
   endfunction

   function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return sat(128'(a) + 128'(b));
   endfunction

   function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return sat(128'(a) - 128'(b));
   endfunction

   function automatic logic signed [31:0] fx_gain(input logic signed [31:0] num,
                                                  input logic signed [31:0] den);
      logic signed [127:0] n;
      if (den <= 0) return 0;
      n = 128'(num) <<< FB;
      return sat(n / 128'(den));
   endfunction

   task automatic reset_filter();
      q_angle = 1049; q_bias = 3146; r_noise = 524288; dt_step = 5243;
      est_angle = 0; est_bias = 0;
      cov[0] = 32'sd1 <<< FB; cov[1] = 0; cov[2] = 0; cov[3] = 32'sd1 <<< FB;
   endtask

   function automatic rsp_payload_type filter_sample(input req_payload_type s);
      logic signed [31:0] dt, d0, dn, p00, p01, p10, p11, err, k0, k1, e;
      rsp_payload_type r;
      dt = dt_step;
      p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      est_angle = fx_add(est_angle, fx_mul(fx_sub(s.gyro_rate, est_bias), dt));
      d0 = fx_sub(fx_sub(q_angle, p01), p10);
      dn = sat(-128'(p11));
      p00 = fx_add(p00, fx_mul(d0, dt));
      p01 = fx_add(p01, fx_mul(dn, dt));
      p10 = fx_add(p10, fx_mul(dn, dt));
      p11 = fx_add(p11, fx_mul(q_bias, dt));
      err = fx_sub(s.accel_angle, est_angle);
      e = sat(128'(r_noise) + 128'(p00));
      k0 = fx_gain(p00, e);
      k1 = fx_gain(p10, e);
      cov[0] = fx_sub(p00, fx_mul(k0, p00));
      cov[1] = fx_sub(p01, fx_mul(k0, p01));
      cov[2] = fx_sub(p10, fx_mul(k1, p00));
      cov[3] = fx_sub(p11, fx_mul(k1, p01));
      est_angle = fx_add(est_angle, fx_mul(k0, err));
      est_bias = fx_add(est_bias, fx_mul(k1, err));
      r.filtered_angle = est_angle;
      r.corrected_rate = fx_sub(s.gyro_rate, est_bias);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("tb_top: %s mismatch got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic idle_burst();
      if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_sample(input req_payload_type s);
      idle_burst();
      req_valid <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(filter_sample(s));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_Q_ANGLE: q_angle = val & 32'h1fffff;
         CSR_Q_BIAS:  q_bias = val & 32'h1fffff;
         CSR_R:       r_noise = val & 32'h1ffffff;
         CSR_DT:      dt_step = val & 32'h1fffff;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // response side: random stall bursts, one long hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (rsp_idle_on && !stim_done && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_gap <= $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_payload[63:32], 0);
         end else begin
            rsp_payload_type w;
            w = expected_rsp.pop_front();
            if (rsp_payload.filtered_angle !== w.filtered_angle)
               report_mismatch("filtered_angle", rsp_payload.filtered_angle, w.filtered_angle);
            if (rsp_payload.corrected_rate !== w.corrected_rate)
               report_mismatch("corrected_rate", rsp_payload.corrected_rate, w.corrected_rate);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      // hold off the receiver long enough for requests to back up
      wait (!reset);
      repeat (150) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (1500) @(posedge clock);
      hold_rsp = 1'b0;
   end

   typedef struct {
      req_payload_type s;
      bit has_want;
      rsp_payload_type want;
   } stim_row_type;

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      req_payload_type s;
      logic signed [31:0] base;
      int n;
      reset_filter();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero sample after reset leaves everything at zero
      rows.push_back('{'{32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0}});
      rows.push_back('{'{32'sh7fffffff, 32'sh7fffffff}, 1'b0, '0});
      rows.push_back('{'{32'sh80000000, 32'sh80000000}, 1'b0, '0});
      rows.push_back('{'{32'sh7fffffff, 32'sh80000000}, 1'b0, '0});
      rows.push_back('{'{32'sh80000000, 32'sh7fffffff}, 1'b0, '0});
      rows.push_back('{'{32'sh00100000, 32'shfff00000}, 1'b0, '0});
      rows.push_back('{'{32'shffffffff, 32'sh00000001}, 1'b0, '0});
      rows.push_back('{'{32'sh55555555, 32'shaaaaaaaa}, 1'b0, '0});
      rows.push_back('{'{32'shaaaaaaaa, 32'sh55555555}, 1'b0, '0});
      foreach (rows[i]) begin
         rsp_payload_type pred;
         send_sample(rows[i].s);
         pred = expected_rsp[$];
         if (rows[i].has_want && pred !== rows[i].want)
            report_mismatch("table", pred[63:32], rows[i].want.filtered_angle);
      end
      drain();

      // extreme settings, including non-positive innovation variance
      write_csr(CSR_R, 32'd0);
      write_csr(CSR_Q_ANGLE, 32'h1fffff);
      write_csr(CSR_Q_BIAS, 32'h1fffff);
      write_csr(CSR_DT, 32'h1fffff);
      write_csr(8'd200, 32'hffffffff);
      for (int i = 0; i < 12; i++) begin
         s.accel_angle = $urandom; s.gyro_rate = $urandom;
         send_sample(s);
      end
      drain();
      write_csr(CSR_R, 32'h1ffffff);
      write_csr(CSR_DT, 32'd0);
      write_csr(CSR_Q_ANGLE, 32'd0);
      write_csr(CSR_Q_BIAS, 32'd0);
      for (int i = 0; i < 10; i++) begin
         s.accel_angle = $urandom; s.gyro_rate = $urandom;
         send_sample(s);
      end
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_Q_ANGLE, $urandom_range(0, 1048576));
         write_csr(CSR_Q_BIAS, $urandom_range(0, 1048576));
         write_csr(CSR_R, $urandom_range(1, 16777216));
         write_csr(CSR_DT, $urandom_range(1, 1048576));
         if (ph == 5) rsp_idle_on = 1'b0;
         n = (ph == 5) ? 60 : 170;
         base = $urandom_range(0, 1) ? $signed($urandom) : $signed($urandom_range(0, 1 << 26)) - (1 << 25);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
               0: begin s.accel_angle = $urandom; s.gyro_rate = $urandom; end
               1: begin
                  s.accel_angle = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                  s.gyro_rate = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
               end
               default: begin
                  // realistic sensor: angle near this phase's base, small rate
                  s.accel_angle = base + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
                  s.gyro_rate = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
               end
            endcase
            send_sample(s);
         end
         drain();
      end
      stim_done = 1'b1;
      drain();
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/agkf_pkg.sv
rtl/agkf_mul.sv
rtl/agkf_div.sv
rtl/angle_gyro_kalman_filter_top.sv
tb/tb_top.sv
